// File: rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, character codes and token kinds for the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam int KEYWORD_SLOTS_DEF = 6;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int POSITION_BITS_DEF = 16;

    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [2:0] REG_KW_COUNT = 3'd0;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam logic [2:0] KIND_SEMI    = 3'd0;
    localparam logic [2:0] KIND_LPAREN  = 3'd1;
    localparam logic [2:0] KIND_RPAREN  = 3'd2;
    localparam logic [2:0] KIND_OP      = 3'd3;
    localparam logic [2:0] KIND_NUMBER  = 3'd4;
    localparam logic [2:0] KIND_IDENT   = 3'd5;
    localparam logic [2:0] KIND_KEYWORD = 3'd6;
    localparam logic [2:0] KIND_ERROR   = 3'd7;

    localparam logic [1:0] RUN_NONE   = 2'd0;
    localparam logic [1:0] RUN_NUMBER = 2'd1;
    localparam logic [1:0] RUN_WORD   = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  chr;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic [31:0] off;
        logic        last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

endpackage

// File: rtl/source_tokenizer_stream_top.sv
// ----------------------------------------------------------------------------
// source_tokenizer_stream_top
// Streaming tokenizer: one source byte per transfer in, tokens out.
// Path: the byte that completes a token is held in the input register, and
//   the token is written to the result queue, from which it is offered.
// Throughput: 1 byte per cycle while the result queue has two free entries;
//   a byte giving two tokens pushes both, and the 4-entry queue absorbs them.
// Reset: synchronous, active low; clears position counters, open run,
//   halt flag, keyword registers and the result queue.
// ----------------------------------------------------------------------------
module source_tokenizer_stream_top import stok_pkg::*; #(
    parameter int KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_character,
    input  logic               s_end_of_source,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_token_kind,
    output logic [7:0]         m_token_char,
    output logic [15:0]        m_token_length,
    output logic [15:0]        m_token_line,
    output logic [15:0]        m_token_column,
    output logic [31:0]        m_token_offset,
    output logic               m_last_of_run
);

    localparam int LW    = (POSITION_BITS >= 16) ? 16 : POSITION_BITS;
    localparam int BUF_W = 8 * KEYWORD_CHARS;

    // configuration
    logic [2:0]  kw_count_reg;
    logic [63:0] kw_reg [KEYWORD_SLOTS];
    logic [2:0]  reg_idx;
    logic        cfg_wr;
    logic [2:0]  kw_cnt_eff;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign kw_cnt_eff = (kw_count_reg > 3'(KEYWORD_SLOTS)) ? 3'(KEYWORD_SLOTS)
                                                           : kw_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_count_reg <= '0;
            for (int i = 0; i < KEYWORD_SLOTS; i++) begin
                kw_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            if (reg_idx == REG_KW_COUNT) begin
                kw_count_reg <= pwdata[2:0];
            end
            for (int i = 0; i < KEYWORD_SLOTS; i++) begin
                if (reg_idx == 3'(i + 1)) begin
                    kw_reg[i] <= pwdata;
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_KW_COUNT) begin
            prdata = PDATA_W'(kw_count_reg);
        end
        for (int i = 0; i < KEYWORD_SLOTS; i++) begin
            if (reg_idx == 3'(i + 1)) begin
                prdata = kw_reg[i];
            end
        end
    end

    // input register
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_eos_reg;
    logic       proc_fire;
    logic [FIFO_CNT_W-1:0] cnt_reg;

    assign proc_fire = in_vld_reg && (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_ready   = !in_vld_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_character;
            in_eos_reg  <= s_end_of_source;
        end
    end

    // tokenizer state
    logic [1:0]       run_kind_reg,  run_kind_next;
    logic [LW-1:0]    run_line_reg,  run_line_next;
    logic [LW-1:0]    run_col_reg,   run_col_next;
    logic [31:0]      run_off_reg,   run_off_next;
    logic [15:0]      run_len_reg,   run_len_next;
    logic [BUF_W-1:0] buffer_reg,    buffer_next;
    logic [LW-1:0]    line_reg,      line_next;
    logic [LW-1:0]    col_reg,       col_next;
    logic [31:0]      off_reg,       off_next;
    logic             halted_reg,    halted_next;

    logic [7:0]       c;
    logic             run_cont;
    logic [BUF_W-1:0] buf_ins;
    logic [15:0]      len_inc;
    logic [LW-1:0]    col_inc, line_inc;
    logic [31:0]      off_inc;
    logic [BUF_W-1:0] cmp_buf;
    logic [15:0]      cmp_len;
    logic             kw_hit;
    logic             kw_match;
    logic [2:0]       word_kind;

    assign c        = in_char_reg;
    assign run_cont = ((run_kind_reg == RUN_NUMBER) && is_digit(c))
                   || ((run_kind_reg == RUN_WORD) && is_word(c));
    assign len_inc  = (&run_len_reg) ? run_len_reg : run_len_reg + 16'd1;
    assign col_inc  = (&col_reg)  ? col_reg  : col_reg  + 1'b1;
    assign line_inc = (&line_reg) ? line_reg : line_reg + 1'b1;
    assign off_inc  = (&off_reg)  ? off_reg  : off_reg  + 32'd1;

    always_comb begin
        for (int j = 0; j < KEYWORD_CHARS; j++) begin
            buf_ins[8*j +: 8] = (run_len_reg == 16'(j)) ? c : buffer_reg[8*j +: 8];
        end
    end

    // the only word that can close in a given cycle
    always_comb begin
        if (run_kind_reg != RUN_NONE && run_cont) begin
            cmp_buf = buf_ins;
            cmp_len = len_inc;
        end else if (run_kind_reg == RUN_WORD) begin
            cmp_buf = buffer_reg;
            cmp_len = run_len_reg;
        end else begin
            cmp_buf = BUF_W'(c);
            cmp_len = 16'd1;
        end
    end

    always_comb begin
        kw_hit = 1'b0;
        for (int i = 0; i < KEYWORD_SLOTS; i++) begin
            if ((3'(i) < kw_cnt_eff) && (kw_reg[i] == 64'(cmp_buf))) begin
                kw_hit = 1'b1;
            end
        end
    end

    assign kw_match  = kw_hit && (cmp_len <= 16'(KEYWORD_CHARS));
    assign word_kind = kw_match ? KIND_KEYWORD : KIND_IDENT;

    token_t     res0, res1, tok;
    logic [1:0] n_res;
    logic       new_run;

    always_comb begin
        run_kind_next = run_kind_reg;
        run_line_next = run_line_reg;
        run_col_next  = run_col_reg;
        run_off_next  = run_off_reg;
        run_len_next  = run_len_reg;
        buffer_next   = buffer_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        off_next      = off_reg;
        halted_next   = halted_reg;
        res0          = '0;
        res1          = '0;
        tok           = '0;
        n_res         = 2'd0;
        new_run       = 1'b0;

        if (proc_fire && !halted_reg) begin
            if (run_kind_reg != RUN_NONE && run_cont) begin
                buffer_next  = buf_ins;
                run_len_next = len_inc;
                col_next     = col_inc;
                off_next     = off_inc;
                if (in_eos_reg) begin
                    res0.kind = (run_kind_reg == RUN_NUMBER) ? KIND_NUMBER : word_kind;
                    res0.chr  = buffer_reg[7:0];
                    res0.len  = len_inc;
                    res0.line = 16'(run_line_reg);
                    res0.col  = 16'(run_col_reg);
                    res0.off  = run_off_reg;
                    n_res     = 2'd1;
                    run_kind_next = RUN_NONE;
                end
            end else begin
                if (run_kind_reg != RUN_NONE) begin
                    res0.kind = (run_kind_reg == RUN_NUMBER) ? KIND_NUMBER : word_kind;
                    res0.chr  = buffer_reg[7:0];
                    res0.len  = run_len_reg;
                    res0.line = 16'(run_line_reg);
                    res0.col  = 16'(run_col_reg);
                    res0.off  = run_off_reg;
                    n_res     = 2'd1;
                    run_kind_next = RUN_NONE;
                end

                tok.chr  = c;
                tok.len  = 16'd1;
                tok.line = 16'(line_reg);
                tok.col  = 16'(col_reg);
                tok.off  = off_reg;

                if (c == CH_SPACE || c == CH_TAB) begin
                    col_next = col_inc;
                    off_next = off_inc;
                end else if (c == CH_NL) begin
                    line_next = line_inc;
                    col_next  = '0;
                    off_next  = off_inc;
                end else if (c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN
                          || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
                          || c == CH_SLASH || c == CH_EQ) begin
                    if (c == CH_SEMI) begin
                        tok.kind = KIND_SEMI;
                    end else if (c == CH_LPAREN) begin
                        tok.kind = KIND_LPAREN;
                    end else if (c == CH_RPAREN) begin
                        tok.kind = KIND_RPAREN;
                    end else begin
                        tok.kind = KIND_OP;
                    end
                    new_run  = 1'b1;
                    col_next = col_inc;
                    off_next = off_inc;
                end else if (is_digit(c) || is_word(c)) begin
                    run_kind_next = is_digit(c) ? RUN_NUMBER : RUN_WORD;
                    run_line_next = line_reg;
                    run_col_next  = col_reg;
                    run_off_next  = off_reg;
                    run_len_next  = 16'd1;
                    buffer_next   = BUF_W'(c);
                    col_next      = col_inc;
                    off_next      = off_inc;
                    if (in_eos_reg) begin
                        tok.kind      = is_digit(c) ? KIND_NUMBER : word_kind;
                        new_run       = 1'b1;
                        run_kind_next = RUN_NONE;
                    end
                end else begin
                    tok.kind    = KIND_ERROR;
                    new_run     = 1'b1;
                    col_next    = col_inc;
                    off_next    = off_inc;
                    halted_next = 1'b1;
                end

                if (new_run) begin
                    if (n_res == 2'd0) begin
                        res0 = tok;
                    end else begin
                        res1 = tok;
                    end
                    n_res = n_res + 2'd1;
                end
            end

            if (in_eos_reg) begin
                line_next = '0;
                col_next  = '0;
                off_next  = '0;
            end

            if (n_res == 2'd1) begin
                res0.last = 1'b1;
            end
            if (n_res == 2'd2) begin
                res1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_kind_reg <= RUN_NONE;
            run_line_reg <= '0;
            run_col_reg  <= '0;
            run_off_reg  <= '0;
            run_len_reg  <= '0;
            buffer_reg   <= '0;
            line_reg     <= '0;
            col_reg      <= '0;
            off_reg      <= '0;
            halted_reg   <= 1'b0;
        end else begin
            run_kind_reg <= run_kind_next;
            run_line_reg <= run_line_next;
            run_col_reg  <= run_col_next;
            run_off_reg  <= run_off_next;
            run_len_reg  <= run_len_next;
            buffer_reg   <= buffer_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            off_reg      <= off_next;
            halted_reg   <= halted_next;
        end
    end

    // result queue
    token_t                fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] push_cnt;

    assign m_valid  = (cnt_reg != '0);
    assign pop      = m_valid && m_ready;
    assign push_cnt = proc_fire ? FIFO_CNT_W'(n_res) : '0;

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            if (n_res != 2'd0) begin
                fifo_mem[wr_ptr_reg] <= res0;
            end
            if (n_res == 2'd2) begin
                fifo_mem[wr_ptr_reg + 1'b1] <= res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + push_cnt - FIFO_CNT_W'(pop);
        end
    end

    assign m_token_kind   = fifo_mem[rd_ptr_reg].kind;
    assign m_token_char   = fifo_mem[rd_ptr_reg].chr;
    assign m_token_length = fifo_mem[rd_ptr_reg].len;
    assign m_token_line   = fifo_mem[rd_ptr_reg].line;
    assign m_token_column = fifo_mem[rd_ptr_reg].col;
    assign m_token_offset = fifo_mem[rd_ptr_reg].off;
    assign m_last_of_run  = fifo_mem[rd_ptr_reg].last;

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && halted_reg) |-> (n_res == 2'd0))
        else $error("token produced while halted");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !proc_fire) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count lost a pop");

endmodule
